// File: rtl/fdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_pkg: shared types and constants
// Mode codes, expander addresses and result item layout for the flip-dot
// panel driver.
// ----------------------------------------------------------------------------
package fdp_pkg;

   typedef enum logic [1:0] {
      MODE_STORE     = 2'd0,
      MODE_REFRESH   = 2'd1,
      MODE_END_FRAME = 2'd2,
      MODE_DIRECT    = 2'd3
   } mode_type;

   // expander addresses
   localparam logic [7:0] ADDR_MODULE = 8'h40;
   localparam logic [7:0] ADDR_COLUMN = 8'h42;
   localparam logic [7:0] ADDR_ROW    = 8'h44;

   localparam logic [7:0] ALL_OFF       = 8'hFF;
   localparam logic [7:0] ROW_KEEP_MASK = 8'h0F;

   // panel geometry of one module
   localparam int MODULE_COLS = 28;
   localparam int DIGIT_ROWS  = 14;
   localparam int SEG_SIZE    = 7;

   // configuration registers (word index)
   localparam logic CSR_FLIP_HOLD = 1'b0;
   localparam logic [15:0] FLIP_HOLD_RESET = 16'd550;

   typedef struct packed {
      logic [7:0]  bus_addr;
      logic [7:0]  bus_data;
      logic [15:0] hold_us;
      logic        last;
   } result_type;

   typedef result_type [3:0] burst_type;

   // store write request, both stores share the stage index
   typedef struct packed {
      logic frame_we;
      logic frame_wd;
      logic shown_we;
      logic shown_wd;
   } store_wr_type;

endpackage
`default_nettype wire

// File: rtl/fdp_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_store: frame and shadow dot memories
// One bit per dot each, registered read, one write port each, and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module fdp_store #(
   parameter int DOT_COUNT = 2128
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire [$clog2(DOT_COUNT)-1:0]  rd_idx,
   input  wire [$clog2(DOT_COUNT)-1:0]  wr_idx,
   input  fdp_pkg::store_wr_type        wr,
   output logic                         frame_rd,
   output logic                         shown_rd,
   output logic                         clear_busy
);
   localparam int IDX_W = $clog2(DOT_COUNT);

   logic frame_mem [DOT_COUNT];
   logic shown_mem [DOT_COUNT];

   logic             frame_rd_ff;
   logic             shown_rd_ff;
   logic             clear_busy_ff;
   logic [IDX_W-1:0] clear_cnt_ff;
   logic [IDX_W-1:0] clear_cnt_in;
   logic             clear_busy_in;

   logic [IDX_W-1:0] waddr;
   logic             frame_we;
   logic             frame_wd;
   logic             shown_we;
   logic             shown_wd;

   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         if (clear_cnt_ff == IDX_W'(DOT_COUNT - 1)) begin
            clear_busy_in = 1'b0;
         end else begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   // clearing pass owns the write ports until done
   always_comb begin
      waddr    = clear_busy_ff ? clear_cnt_ff : wr_idx;
      frame_we = clear_busy_ff | wr.frame_we;
      shown_we = clear_busy_ff | wr.shown_we;
      frame_wd = ~clear_busy_ff & wr.frame_wd;
      shown_wd = ~clear_busy_ff & wr.shown_wd;
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[waddr] <= frame_wd;
      end
      if (shown_we) begin
         shown_mem[waddr] <= shown_wd;
      end
      if (rd_en) begin
         frame_rd_ff <= frame_mem[rd_idx];
         shown_rd_ff <= shown_mem[rd_idx];
      end
   end

   assign frame_rd   = frame_rd_ff;
   assign shown_rd   = shown_rd_ff;
   assign clear_busy = clear_busy_ff;

endmodule
`default_nettype wire

// File: rtl/fdp_flip_enc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_flip_enc: expander write encoder
// Maps a dot and its state to the four-write flip sequence, or builds the
// single disable-all write for end of frame.
// ----------------------------------------------------------------------------
module fdp_flip_enc (
   input  fdp_pkg::mode_type   mode,
   input  wire [6:0]           x,
   input  wire [4:0]           y,
   input  wire                 dot_state,
   input  wire [15:0]          flip_hold,
   output fdp_pkg::burst_type  burst
);
   logic [1:0] mod_q;
   logic [6:0] mod_base;
   logic [4:0] col_rem;
   logic [1:0] col_digit;
   logic [2:0] col_seg;
   logic [4:0] y_rem;
   logic       row_hi;
   logic [2:0] row_seg;
   logic       low_drv;
   logic [4:0] ca;
   logic [4:0] ra;
   logic [4:0] cp;
   logic [4:0] rp;
   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;
   logic [4:0] col_rem_seg;
   logic [4:0] y_rem_seg;

   always_comb begin
      // x / 28 by compare, x below 112 on the panel
      if (x >= 7'(3 * fdp_pkg::MODULE_COLS)) begin
         mod_q = 2'd3;
      end else if (x >= 7'(2 * fdp_pkg::MODULE_COLS)) begin
         mod_q = 2'd2;
      end else if (x >= 7'(fdp_pkg::MODULE_COLS)) begin
         mod_q = 2'd1;
      end else begin
         mod_q = 2'd0;
      end
      mod_base = 7'(fdp_pkg::MODULE_COLS) * 7'(mod_q);
      col_rem  = 5'(x - mod_base);

      if (col_rem >= 5'(3 * fdp_pkg::SEG_SIZE)) begin
         col_digit = 2'd3;
      end else if (col_rem >= 5'(2 * fdp_pkg::SEG_SIZE)) begin
         col_digit = 2'd2;
      end else if (col_rem >= 5'(fdp_pkg::SEG_SIZE)) begin
         col_digit = 2'd1;
      end else begin
         col_digit = 2'd0;
      end
      col_rem_seg = col_rem - 5'(fdp_pkg::SEG_SIZE) * 5'(col_digit) + 5'd1;
      col_seg     = col_rem_seg[2:0];

      low_drv = (y < 5'(fdp_pkg::DIGIT_ROWS));
      y_rem   = low_drv ? y : 5'(y - 5'(fdp_pkg::DIGIT_ROWS));
      row_hi  = (y_rem >= 5'(fdp_pkg::SEG_SIZE));
      y_rem_seg = (row_hi ? 5'(y_rem - 5'(fdp_pkg::SEG_SIZE)) : y_rem) + 5'd1;
      row_seg = y_rem_seg[2:0];

      ca = {col_digit, col_seg};
      ra = {row_hi, ~dot_state, row_seg};
      // column fully reversed; row: low three reversed, upper two swapped
      cp = {ca[0], ca[1], ca[2], ca[3], ca[4]};
      rp = {ra[3], ra[4], ra[0], ra[1], ra[2]};

      b0 = ~(8'd1 << mod_q);
      b1 = {rp[0], ~dot_state, cp, 1'b0};
      b2 = {~low_drv, dot_state, low_drv, dot_state, rp[4:1]};

      burst[0] = '{bus_addr: fdp_pkg::ADDR_MODULE, bus_data: b0,
                   hold_us: 16'd0, last: 1'b0};
      burst[1] = '{bus_addr: fdp_pkg::ADDR_COLUMN, bus_data: b1,
                   hold_us: 16'd0, last: 1'b0};
      burst[2] = '{bus_addr: fdp_pkg::ADDR_ROW, bus_data: b2,
                   hold_us: flip_hold, last: 1'b0};
      burst[3] = '{bus_addr: fdp_pkg::ADDR_ROW,
                   bus_data: b2 & fdp_pkg::ROW_KEEP_MASK,
                   hold_us: 16'd0, last: 1'b1};
      if (mode == fdp_pkg::MODE_END_FRAME) begin
         burst[0] = '{bus_addr: fdp_pkg::ADDR_MODULE, bus_data: fdp_pkg::ALL_OFF,
                      hold_us: 16'd0, last: 1'b1};
      end
   end

endmodule
`default_nettype wire

// File: rtl/fdp_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_emit: result sequencer
// Holds one burst of writes and hands them out one item per cycle, while
// rsp_stall is low, until the write marked last is taken.
// ----------------------------------------------------------------------------
module fdp_emit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  fdp_pkg::burst_type   burst_in,
   output logic                 free,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output fdp_pkg::result_type  rsp_item
);
   fdp_pkg::burst_type burst_ff;
   logic [1:0]         pos_ff;
   logic [1:0]         pos_in;
   logic               busy_ff;
   logic               busy_in;
   logic               take;

   assign rsp_item  = burst_ff[pos_ff];
   assign rsp_valid = busy_ff;
   assign take      = busy_ff & ~rsp_stall;
   // free for a new burst at this edge
   assign free      = ~busy_ff | (take & rsp_item.last);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (take) begin
         if (rsp_item.last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pos_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/flip_dot_panel_driver.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item waits in the stage register; its writes are loaded into the
// result sequencer as it leaves. Store and off-panel items give no writes, a
// flip four and end of frame one, one write per cycle while rsp_stall is low.
// Reset: a clearing pass over PANEL_WIDTH*PANEL_HEIGHT dots (2128 by default)
// zeroes both dot stores; no item is accepted meanwhile, csr writes are.
// ----------------------------------------------------------------------------
// flip_dot_panel_driver: flip-dot panel expander write generator
// Keeps a frame store and a shadow of the shown dots and turns dot requests
// into module/column/row expander writes.
// ----------------------------------------------------------------------------
module flip_dot_panel_driver #(
   parameter int PANEL_WIDTH  = 112,
   parameter int PANEL_HEIGHT = 19
) (
   input  wire         clock,
   input  wire         reset,
   // input items
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_mode,
   input  wire  [6:0]  req_x,
   input  wire  [4:0]  req_y,
   input  wire         req_dot_on,
   // result items
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_bus_addr,
   output logic [7:0]  rsp_bus_data,
   output logic [15:0] rsp_hold_us,
   output logic        rsp_last,
   // configuration
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int DOT_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
   localparam int IDX_W     = $clog2(DOT_COUNT);

   // ---------------------------------------------------------------------
   // Configuration: one register, word index in paddr[2]
   // ---------------------------------------------------------------------
   logic [15:0] flip_hold_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr[2] == fdp_pkg::CSR_FLIP_HOLD) ? {16'd0, flip_hold_ff}
                                                           : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_hold_ff <= fdp_pkg::FLIP_HOLD_RESET;
      end else if (csr_write && paddr[2] == fdp_pkg::CSR_FLIP_HOLD) begin
         flip_hold_ff <= pwdata[15:0];
      end
   end

   // ---------------------------------------------------------------------
   // Input decode: panel bounds and dot index. The store read is issued
   // at the accept edge so the bits are ready while the item sits in the
   // stage register.
   // ---------------------------------------------------------------------
   logic             accept;
   logic             on_panel;
   logic [IDX_W-1:0] req_idx;

   assign on_panel = (32'(req_x) < 32'(PANEL_WIDTH)) && (32'(req_y) < 32'(PANEL_HEIGHT));
   assign req_idx  = IDX_W'(32'(req_y) * 32'(PANEL_WIDTH) + 32'(req_x));

   // ---------------------------------------------------------------------
   // Stage register
   // ---------------------------------------------------------------------
   logic              s1_valid_ff;
   fdp_pkg::mode_type s1_mode_ff;
   logic [6:0]        s1_x_ff;
   logic [4:0]        s1_y_ff;
   logic              s1_dot_ff;
   logic              s1_on_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   // one-deep bypass: a write leaving the stage at the edge where the next
   // item reads the same dot is not yet visible in the store read data
   logic              fwd_frame_vld_ff;
   logic              fwd_frame_ff;
   logic              fwd_shown_vld_ff;
   logic              fwd_shown_ff;

   logic              frame_rd;
   logic              shown_rd;
   logic              clear_busy;
   logic              frame_eff;
   logic              shown_eff;
   logic              changed;
   logic              has_results;
   logic              s1_adv;
   logic              emit_free;
   logic              dot_state;
   fdp_pkg::store_wr_type store_wr;
   fdp_pkg::burst_type    burst;
   fdp_pkg::result_type   rsp_item;

   assign frame_eff = fwd_frame_vld_ff ? fwd_frame_ff : frame_rd;
   assign shown_eff = fwd_shown_vld_ff ? fwd_shown_ff : shown_rd;
   assign changed   = frame_eff ^ shown_eff;

   always_comb begin
      has_results = 1'b0;
      case (s1_mode_ff)
         fdp_pkg::MODE_END_FRAME: has_results = 1'b1;
         fdp_pkg::MODE_DIRECT:    has_results = s1_on_ff;
         fdp_pkg::MODE_REFRESH:   has_results = s1_on_ff & changed;
         default:                 has_results = 1'b0;
      endcase
   end

   // no-write items leave the stage at once, others once the sequencer is free
   assign s1_adv    = s1_valid_ff & (~has_results | emit_free);
   assign req_stall = clear_busy | (s1_valid_ff & ~s1_adv);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      store_wr.frame_we = s1_adv & s1_on_ff & (s1_mode_ff == fdp_pkg::MODE_STORE);
      store_wr.frame_wd = s1_dot_ff;
      store_wr.shown_we = s1_adv & s1_on_ff & (s1_mode_ff == fdp_pkg::MODE_REFRESH)
                          & changed;
      store_wr.shown_wd = frame_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         fwd_frame_vld_ff <= 1'b0;
         fwd_shown_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff      <= 1'b1;
            fwd_frame_vld_ff <= store_wr.frame_we & (s1_idx_ff == req_idx);
            fwd_shown_vld_ff <= store_wr.shown_we & (s1_idx_ff == req_idx);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff   <= fdp_pkg::mode_type'(req_mode);
         s1_x_ff      <= req_x;
         s1_y_ff      <= req_y;
         s1_dot_ff    <= req_dot_on;
         s1_on_ff     <= on_panel;
         s1_idx_ff    <= req_idx;
         fwd_frame_ff <= store_wr.frame_wd;
         fwd_shown_ff <= store_wr.shown_wd;
      end
   end

   fdp_store #(
      .DOT_COUNT (DOT_COUNT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept & on_panel),
      .rd_idx     (req_idx),
      .wr_idx     (s1_idx_ff),
      .wr         (store_wr),
      .frame_rd   (frame_rd),
      .shown_rd   (shown_rd),
      .clear_busy (clear_busy)
   );

   // refresh drives the stored frame bit, direct drive the requested one
   assign dot_state = (s1_mode_ff == fdp_pkg::MODE_DIRECT) ? s1_dot_ff : frame_eff;

   fdp_flip_enc u_enc (
      .mode      (s1_mode_ff),
      .x         (s1_x_ff),
      .y         (s1_y_ff),
      .dot_state (dot_state),
      .flip_hold (flip_hold_ff),
      .burst     (burst)
   );

   // ---------------------------------------------------------------------
   // Result sequencer: while rsp_stall is low, one expander write per cycle
   // ---------------------------------------------------------------------
   fdp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv & has_results),
      .burst_in  (burst),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_bus_addr = rsp_item.bus_addr;
   assign rsp_bus_data = rsp_item.bus_data;
   assign rsp_hold_us  = rsp_item.hold_us;
   assign rsp_last     = rsp_item.last;

endmodule
`default_nettype wire
